/* rtl/sorted_int_table_unit_assert.svh */
// Assertion macros for the sorted integer table top level.
`ifndef SORTED_INT_TABLE_UNIT_ASSERT_SVH
`define SORTED_INT_TABLE_UNIT_ASSERT_SVH

// Checked only while the block is out of reset.
`define SIT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define SIT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/sit_pkg.sv */
// Shared types and constants for the sorted integer table.
package sit_pkg;

  // Default sizes of the table.
  localparam int DEPTH_DEF   = 256;
  localparam int VALUE_W_DEF = 32;

  // Field widths fixed by the request and result formats.
  localparam int REQ_W    = 3;
  localparam int STATUS_W = 2;

  // Request codes.
  localparam logic [REQ_W-1:0] REQ_FIND     = 3'd0;
  localparam logic [REQ_W-1:0] REQ_FIRST_GE = 3'd1;
  localparam logic [REQ_W-1:0] REQ_FIRST_GT = 3'd2;
  localparam logic [REQ_W-1:0] REQ_SORT_INS = 3'd3;
  localparam logic [REQ_W-1:0] REQ_INS_AT   = 3'd4;
  localparam logic [REQ_W-1:0] REQ_REM_AT   = 3'd5;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_DUP     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_POS = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd3;

  // Sequencer states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_COMPARE,
    S_SEARCH,
    S_FINISH
  } state_t;

  // Per-cycle commands broadcast to every cell.
  typedef struct packed {
    logic cmp;  // latch compare flags against the key
    logic ins;  // open a slot at the target position and write the key
    logic rem;  // close the slot at the target position
  } cell_ctl_t;

endpackage

/* rtl/sit_cell.sv */
// One table cell: holds one entry, shifts with its neighbors, compares against the key.
module sit_cell #(
  parameter int CELL_IDX    = 0,
  parameter int VALUE_WIDTH = sit_pkg::VALUE_W_DEF,
  parameter int IDX_W       = 9
) (
  input  logic                          clk,
  input  sit_pkg::cell_ctl_t            ctl,
  input  logic signed [VALUE_WIDTH-1:0] key,
  input  logic [IDX_W-1:0]              pos,
  input  logic signed [VALUE_WIDTH-1:0] left_val,
  input  logic signed [VALUE_WIDTH-1:0] right_val,
  output logic signed [VALUE_WIDTH-1:0] entry_val,
  output logic                          lt_flag,
  output logic                          eq_flag
);
  import sit_pkg::*;

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

  logic signed [VALUE_WIDTH-1:0] entry_r;
  logic signed [VALUE_WIDTH-1:0] entry_nxt;
  logic                          lt_r;
  logic                          eq_r;

  // Insert moves the tail one place right, remove one place left.
  always_comb begin
    entry_nxt = entry_r;
    if (ctl.ins) begin
      if (MY_IDX == pos) begin
        entry_nxt = key;
      end else if (MY_IDX > pos) begin
        entry_nxt = left_val;
      end
    end else if (ctl.rem) begin
      if (MY_IDX >= pos) begin
        entry_nxt = right_val;
      end
    end
  end

  // Entry and compare flags are payload and need no reset.
  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
    if (ctl.cmp) begin
      lt_r <= (entry_r < key);
      eq_r <= (entry_r == key);
    end
  end

  assign entry_val = entry_r;
  assign lt_flag   = lt_r;
  assign eq_flag   = eq_r;

endmodule

/* rtl/sorted_int_table_unit.sv */
// Top level of the sorted integer table: request sequencer, binary search and the cell row.
//
// The block keeps up to DEPTH signed entries and a count. A request beat on the in_ channel
// (in_valid high, in_stall low) carries a request type, a value and a position. Each
// request gives exactly one result beat on the out_ channel: an index, a status and the
// entry count after the request. Searches probe one entry per cycle: after the key is
// accepted every cell compares its entry with it in the compare state, then the search
// halves the range once per step, at most ceil(log2(count+1)) steps (9 for a full table
// of 256), then the decide state decides and, for inserts and removes, shifts every cell
// at once. Searches and sorted inserts go through compare, search (skipped when the table is
// empty) and decide; insert-at, remove-at and unknown requests go from idle to decide.
// One request is in work at a time; in_stall is high while it is. The result sits in an
// output register, so a new request is taken while the receiver stalls a finished
// result; the next result waits in the decide cycle until that register frees.
// Reset (rst_n low, synchronous) empties the table and drops any pending result; entry
// contents are left as they are and are not read before they are written again.
module sorted_int_table_unit #(
  parameter int  DEPTH       = sit_pkg::DEPTH_DEF,
  parameter int  VALUE_WIDTH = sit_pkg::VALUE_W_DEF,
  localparam int IDX_W       = $clog2(DEPTH + 1)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [sit_pkg::REQ_W-1:0]     in_req_type,
  input  logic signed [VALUE_WIDTH-1:0] in_value,
  input  logic [IDX_W-1:0]              in_position,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [IDX_W-1:0]              out_index,
  output logic [sit_pkg::STATUS_W-1:0]  out_status,
  output logic [IDX_W-1:0]              out_entry_count
);
  import sit_pkg::*;

  localparam int               AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [IDX_W-1:0] DEPTH_IDX = IDX_W'(DEPTH);

  // Request registers.
  state_t                        state_r, state_nxt;
  logic [REQ_W-1:0]              req_r;
  logic signed [VALUE_WIDTH-1:0] key_r;
  logic [IDX_W-1:0]              pos_r;
  logic [IDX_W-1:0]              count_r;

  // Search bounds: lo and hi+1 of the model.
  logic [IDX_W-1:0] lo_r, lo_nxt;
  logic [IDX_W-1:0] hip1_r, hip1_nxt;
  logic [IDX_W:0]   mid_sum;
  logic [IDX_W-1:0] mid;
  logic             go_right;

  // Output register.
  logic                out_valid_r;
  logic [IDX_W-1:0]    out_index_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [IDX_W-1:0]    out_count_r;

  // Decide-cycle results.
  logic                accept;
  logic                out_free;
  logic                fire;
  logic                found_eq;
  logic                full;
  logic                do_ins;
  logic                do_rem;
  logic [IDX_W-1:0]    tgt_pos;
  logic [IDX_W-1:0]    res_index;
  logic [STATUS_W-1:0] res_status;
  cell_ctl_t           cell_ctl;

  // Cell row signals.
  logic signed [VALUE_WIDTH-1:0] entry_vec [DEPTH];
  logic [DEPTH-1:0]              lt_vec;
  logic [DEPTH-1:0]              eq_vec;

  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign full     = (count_r >= DEPTH_IDX);

  // One binary search step: probe the flag of the middle entry.
  assign mid_sum  = {1'b0, lo_r} + {1'b0, hip1_r} - (IDX_W + 1)'(1);
  assign mid      = mid_sum[IDX_W:1];
  assign go_right = (req_r == REQ_FIRST_GT) ? (lt_vec[mid[AW-1:0]] || eq_vec[mid[AW-1:0]])
                                            : lt_vec[mid[AW-1:0]];

  always_comb begin
    lo_nxt   = lo_r;
    hip1_nxt = hip1_r;
    if (go_right) begin
      lo_nxt = mid + IDX_W'(1);
    end else begin
      hip1_nxt = mid;
    end
  end

  // Equal-entry check at the search result.
  assign found_eq = (hip1_r < count_r) && eq_vec[hip1_r[AW-1:0]];

  // Result and table update for the finished request.
  always_comb begin
    res_index  = count_r;
    res_status = ST_OK;
    do_ins     = 1'b0;
    do_rem     = 1'b0;
    tgt_pos    = pos_r;
    case (req_r)
      REQ_FIND: begin
        res_index = found_eq ? hip1_r : count_r;
      end
      REQ_FIRST_GE, REQ_FIRST_GT: begin
        res_index = hip1_r;
      end
      REQ_SORT_INS: begin
        res_index = hip1_r;
        tgt_pos   = hip1_r;
        if (found_eq) begin
          res_status = ST_DUP;
        end else if (full) begin
          res_status = ST_FULL;
        end else begin
          do_ins = 1'b1;
        end
      end
      REQ_INS_AT: begin
        res_index = pos_r;
        if (pos_r > count_r) begin
          res_status = ST_BAD_POS;
        end else if (full) begin
          res_status = ST_FULL;
        end else begin
          do_ins = 1'b1;
        end
      end
      REQ_REM_AT: begin
        res_index = pos_r;
        if (pos_r >= count_r) begin
          res_status = ST_BAD_POS;
        end else begin
          do_rem = 1'b1;
        end
      end
      default: begin
        res_index  = count_r;
        res_status = ST_BAD_POS;
      end
    endcase
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_req_type == REQ_FIND || in_req_type == REQ_FIRST_GE ||
              in_req_type == REQ_FIRST_GT || in_req_type == REQ_SORT_INS) begin
            state_nxt = S_COMPARE;
          end else begin
            state_nxt = S_FINISH;
          end
        end
      end
      S_COMPARE: begin
        state_nxt = (count_r == '0) ? S_FINISH : S_SEARCH;
      end
      S_SEARCH: begin
        if (lo_nxt >= hip1_nxt) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    in_stall     = 1'b1;
    fire         = 1'b0;
    cell_ctl.cmp = 1'b0;
    cell_ctl.ins = 1'b0;
    cell_ctl.rem = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
      end
      S_COMPARE: begin
        cell_ctl.cmp = 1'b1;
      end
      S_SEARCH: begin
        in_stall = 1'b1;
      end
      S_FINISH: begin
        fire         = out_free;
        cell_ctl.ins = out_free && do_ins;
        cell_ctl.rem = out_free && do_rem;
      end
      default: in_stall = 1'b1;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cell_ctl.ins) begin
        count_r <= count_r + IDX_W'(1);
      end else if (cell_ctl.rem) begin
        count_r <= count_r - IDX_W'(1);
      end
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Request, search and result payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      req_r <= in_req_type;
      key_r <= in_value;
      pos_r <= in_position;
    end
    if (state_r == S_COMPARE) begin
      lo_r   <= '0;
      hip1_r <= count_r;
    end else if (state_r == S_SEARCH) begin
      lo_r   <= lo_nxt;
      hip1_r <= hip1_nxt;
    end
    if (fire) begin
      out_index_r  <= res_index;
      out_status_r <= res_status;
      if (do_ins) begin
        out_count_r <= count_r + IDX_W'(1);
      end else if (do_rem) begin
        out_count_r <= count_r - IDX_W'(1);
      end else begin
        out_count_r <= count_r;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_index       = out_index_r;
  assign out_status      = out_status_r;
  assign out_entry_count = out_count_r;

  // Row of cells, each linked to both neighbors.
  for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
    logic signed [VALUE_WIDTH-1:0] left_val;
    logic signed [VALUE_WIDTH-1:0] right_val;

    if (gi == 0) begin : g_first
      assign left_val = entry_vec[gi];
    end else begin : g_mid_left
      assign left_val = entry_vec[gi-1];
    end

    if (gi == DEPTH - 1) begin : g_last
      assign right_val = entry_vec[gi];
    end else begin : g_mid_right
      assign right_val = entry_vec[gi+1];
    end

    sit_cell #(
      .CELL_IDX   (gi),
      .VALUE_WIDTH(VALUE_WIDTH),
      .IDX_W      (IDX_W)
    ) u_cell (
      .clk      (clk),
      .ctl      (cell_ctl),
      .key      (key_r),
      .pos      (tgt_pos),
      .left_val (left_val),
      .right_val(right_val),
      .entry_val(entry_vec[gi]),
      .lt_flag  (lt_vec[gi]),
      .eq_flag  (eq_vec[gi])
    );
  end

  // Checks on the sequencer and the entry count.
`include "sorted_int_table_unit_assert.svh"

  `SIT_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> (state_r == S_IDLE && !out_valid_r), "sequencer not idle after reset")
  `SIT_ASSERT(a_count_bound, count_r <= DEPTH_IDX, "entry count above table depth")
  `SIT_ASSERT(a_search_range, (state_r == S_SEARCH) |-> (lo_r < hip1_r && hip1_r <= count_r), "search range out of order")
  `SIT_ASSERT(a_count_only_on_finish, (state_r != S_FINISH) |=> $stable(count_r), "entry count changed outside the decide cycle")

endmodule

/* sim/tb_sorted_int_table_unit.sv */
// Self-checking testbench for the sorted integer table: directed and random requests.
module tb_sorted_int_table_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import sit_pkg::*;

  localparam int DEPTH = DEPTH_DEF;
  localparam int VW    = VALUE_W_DEF;
  localparam int IDX_W = $clog2(DEPTH + 1);

  // Request codes the block does not implement; they must come back as bad position.
  localparam logic [REQ_W-1:0] REQ_RSVD6 = 3'd6;
  localparam logic [REQ_W-1:0] REQ_RSVD7 = 3'd7;

  localparam logic signed [VW-1:0] VAL_MIN = {1'b1, {(VW-1){1'b0}}};
  localparam logic signed [VW-1:0] VAL_MAX = {1'b0, {(VW-1){1'b1}}};
  localparam logic [IDX_W-1:0]     IDX_MAX = '1;

  // Cycles without any beat on either channel before the run is declared hung.
  localparam int unsigned HANG_LIMIT = 1000;
  // Longest request-to-result latency of the block plus some margin.
  localparam int unsigned DRAIN_CYCLES = 16;

  typedef struct {
    logic [IDX_W-1:0]    index;
    logic [STATUS_W-1:0] status;
    logic [IDX_W-1:0]    entry_count;
  } table_result_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic [REQ_W-1:0]     in_req_type;
  logic signed [VW-1:0] in_value;
  logic [IDX_W-1:0]     in_position;
  logic                 out_valid;
  logic                 out_stall;
  logic [IDX_W-1:0]     out_index;
  logic [STATUS_W-1:0]  out_status;
  logic [IDX_W-1:0]     out_entry_count;

  // Shadow copy of the table contents; its size is the entry count.
  logic signed [VW-1:0] shadow_entries[$];
  table_result_t        pending_results[$];
  int unsigned          failures;
  int unsigned          quiet_cycles;
  int unsigned          tx_gap_max;
  int unsigned          rx_gap_max;

  sorted_int_table_unit dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_req_type     (in_req_type),
    .in_value        (in_value),
    .in_position     (in_position),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_index       (out_index),
    .out_status      (out_status),
    .out_entry_count (out_entry_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Binary search over the shadow table: first entry at or above the key, or strictly
  // above it when strict is set. Returns hi+1 exactly as the block's search does.
  function automatic int search_bound(input logic signed [VW-1:0] key, input bit strict);
    int lo;
    int hi;
    int mid;
    bit go_right;
    lo = 0;
    hi = shadow_entries.size() - 1;
    while (lo <= hi) begin
      mid = (lo + hi) / 2;
      go_right = strict ? (shadow_entries[mid] <= key) : (shadow_entries[mid] < key);
      if (go_right) lo = mid + 1;
      else hi = mid - 1;
    end
    return hi + 1;
  endfunction

  // Applies one request to the shadow table and returns the result it must produce.
  function automatic table_result_t table_response(input logic [REQ_W-1:0] req,
                                                   input logic signed [VW-1:0] key,
                                                   input logic [IDX_W-1:0] pos);
    table_result_t r;
    int n;
    int idx;
    n = shadow_entries.size();
    idx = n;
    r.status = ST_OK;
    case (req)
      REQ_FIND: begin
        idx = search_bound(key, 1'b0);
        if (idx < n && shadow_entries[idx] != key) idx = n;
      end
      REQ_FIRST_GE: idx = search_bound(key, 1'b0);
      REQ_FIRST_GT: idx = search_bound(key, 1'b1);
      REQ_SORT_INS: begin
        idx = search_bound(key, 1'b0);
        if (idx < n && shadow_entries[idx] == key) r.status = ST_DUP;
        else if (n >= DEPTH) r.status = ST_FULL;
        else shadow_entries.insert(idx, key);
      end
      REQ_INS_AT: begin
        idx = int'(pos);
        if (idx > n) r.status = ST_BAD_POS;
        else if (n >= DEPTH) r.status = ST_FULL;
        else shadow_entries.insert(idx, key);
      end
      REQ_REM_AT: begin
        idx = int'(pos);
        if (idx >= n) r.status = ST_BAD_POS;
        else shadow_entries.delete(idx);
      end
      default: r.status = ST_BAD_POS;
    endcase
    r.index = IDX_W'(idx);
    r.entry_count = IDX_W'(shadow_entries.size());
    return r;
  endfunction

  // Drives one request beat after a random gap and records its expected result
  // once the block takes it.
  task automatic send_request(input logic [REQ_W-1:0] req, input logic signed [VW-1:0] val,
                              input logic [IDX_W-1:0] pos);
    int unsigned gap;
    gap = $urandom_range(0, tx_gap_max);
    repeat (gap) begin
      @(negedge clk);
      in_valid = 1'b0;
    end
    @(negedge clk);
    in_valid    = 1'b1;
    in_req_type = req;
    in_value    = val;
    in_position = pos;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(table_response(req, val, pos));
  endtask

  // Keys are drawn mostly near what the table holds so that hits and duplicates are common.
  function automatic logic signed [VW-1:0] pick_value();
    int unsigned sel;
    int unsigned n;
    sel = $urandom_range(0, 9);
    n = shadow_entries.size();
    if (n > 0 && sel < 3) return shadow_entries[$urandom_range(0, n - 1)];
    if (n > 0 && sel < 5)
      return shadow_entries[$urandom_range(0, n - 1)] + ($urandom_range(0, 1) ? 1 : -1);
    if (sel == 5) return $urandom_range(0, 1) ? VAL_MIN : VAL_MAX;
    if (sel < 8) return VW'(int'($urandom_range(0, 16)) - 8);
    return $urandom;
  endfunction

  // Positions mostly land inside the legal range, sometimes anywhere the field allows.
  function automatic logic [IDX_W-1:0] pick_position(input int unsigned limit);
    if ($urandom_range(0, 7) == 0) return IDX_W'($urandom_range(0, (1 << IDX_W) - 1));
    return IDX_W'($urandom_range(0, limit));
  endfunction

  // Searches, rejects and unknown codes on a table with no entries.
  task automatic test_empty_table();
    send_request(REQ_FIND, '0, '0);
    send_request(REQ_FIRST_GE, VAL_MIN, '0);
    send_request(REQ_FIRST_GT, VAL_MAX, IDX_MAX);
    send_request(REQ_REM_AT, '0, '0);
    send_request(REQ_INS_AT, VAL_MAX, IDX_W'(1));
    send_request(REQ_RSVD6, VAL_MIN, '0);
    send_request(REQ_RSVD7, VAL_MAX, IDX_MAX);
  endtask

  // Extreme keys, duplicates, insert at the end, searches past both ends, bad positions.
  task automatic test_boundary_values();
    send_request(REQ_INS_AT, VAL_MIN, '0);
    send_request(REQ_SORT_INS, VAL_MAX, '0);
    send_request(REQ_SORT_INS, '0, '0);
    send_request(REQ_SORT_INS, '0, IDX_MAX);
    send_request(REQ_INS_AT, VAL_MAX, IDX_W'(3));
    send_request(REQ_FIND, VAL_MAX, '0);
    send_request(REQ_FIRST_GE, VAL_MAX, '0);
    send_request(REQ_FIRST_GT, VAL_MAX, '0);
    send_request(REQ_FIRST_GT, VAL_MIN, '0);
    send_request(REQ_FIND, 5, '0);
    send_request(REQ_FIRST_GE, -1, '0);
    send_request(REQ_INS_AT, 7, IDX_W'(DEPTH));
    send_request(REQ_INS_AT, 7, IDX_MAX);
    send_request(REQ_REM_AT, '0, IDX_W'(4));
    send_request(REQ_REM_AT, '0, IDX_W'(3));
    send_request(REQ_REM_AT, '0, '0);
    send_request(REQ_FIND, VAL_MIN, '0);
    send_request(REQ_SORT_INS, VAL_MIN, '0);
  endtask

  // Fills the table, checks full and duplicate handling at capacity, then empties it.
  task automatic test_full_table();
    logic signed [VW-1:0] v;
    logic [IDX_W-1:0] p;
    tx_gap_max = 0;
    rx_gap_max = 0;
    while (shadow_entries.size() < DEPTH)
      send_request(REQ_SORT_INS, $urandom, IDX_W'($urandom_range(0, (1 << IDX_W) - 1)));
    tx_gap_max = 3;
    rx_gap_max = 3;
    send_request(REQ_SORT_INS, shadow_entries[$urandom_range(0, DEPTH - 1)], '0);
    send_request(REQ_SORT_INS, $urandom, '0);
    send_request(REQ_INS_AT, pick_value(), IDX_W'(DEPTH));
    send_request(REQ_INS_AT, pick_value(), '0);
    send_request(REQ_INS_AT, pick_value(), IDX_W'(DEPTH + 1));
    send_request(REQ_REM_AT, '0, IDX_W'(DEPTH));
    send_request(REQ_FIND, VAL_MAX, '0);
    send_request(REQ_FIRST_GT, VAL_MAX, '0);
    send_request(REQ_FIRST_GE, VAL_MIN, '0);
    // Searches over the longest possible range.
    repeat (20) begin
      case ($urandom_range(0, 2))
        0: send_request(REQ_FIND, pick_value(), '0);
        1: send_request(REQ_FIRST_GE, pick_value(), '0);
        default: send_request(REQ_FIRST_GT, pick_value(), '0);
      endcase
    end
    // Remove one entry and put it back in the same place.
    p = IDX_W'($urandom_range(0, DEPTH - 1));
    v = shadow_entries[p];
    send_request(REQ_REM_AT, '0, p);
    send_request(REQ_INS_AT, v, p);
    // Drain at random positions.
    while (shadow_entries.size() > 0)
      send_request(REQ_REM_AT, '0, IDX_W'($urandom_range(0, shadow_entries.size() - 1)));
  endtask

  // Random mix of all request types with the table growing slowly.
  task automatic run_mixed_ops(input int unsigned num_items);
    int unsigned sel;
    int unsigned n;
    logic [IDX_W-1:0] any_pos;
    repeat (num_items) begin
      sel = $urandom_range(0, 99);
      n = shadow_entries.size();
      any_pos = IDX_W'($urandom_range(0, (1 << IDX_W) - 1));
      if (sel < 12) send_request(REQ_FIND, pick_value(), any_pos);
      else if (sel < 22) send_request(REQ_FIRST_GE, pick_value(), any_pos);
      else if (sel < 32) send_request(REQ_FIRST_GT, pick_value(), any_pos);
      else if (sel < 57) send_request(REQ_SORT_INS, pick_value(), any_pos);
      else if (sel < 70) send_request(REQ_INS_AT, pick_value(), pick_position(n));
      else if (sel < 95) send_request(REQ_REM_AT, pick_value(), pick_position(n > 0 ? n - 1 : 0));
      else send_request($urandom_range(0, 1) ? REQ_RSVD6 : REQ_RSVD7, pick_value(), any_pos);
    end
  endtask

  task automatic test_mixed_traffic();
    tx_gap_max = 3;
    rx_gap_max = 3;
    run_mixed_ops(150);
    tx_gap_max = 0;
    rx_gap_max = 0;
    run_mixed_ops(150);
    tx_gap_max = 3;
    rx_gap_max = 0;
    run_mixed_ops(150);
    tx_gap_max = 0;
    rx_gap_max = 3;
    run_mixed_ops(150);
  endtask

  // Result side: stall for a random number of cycles before taking each beat.
  initial begin : result_receiver
    int unsigned hold;
    out_stall = 1'b0;
    wait (rst_n);
    forever begin
      hold = $urandom_range(0, rx_gap_max);
      repeat (hold) begin
        @(negedge clk);
        out_stall = 1'b1;
      end
      @(negedge clk);
      out_stall = 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  // Compare every accepted result beat with the oldest expected one.
  always @(posedge clk) begin : result_checker
    table_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result beat with nothing expected: index %0d status %0d entry_count %0d",
               out_index, out_status, out_entry_count);
        failures++;
      end else begin
        want = pending_results.pop_front();
        if (out_index !== want.index) begin
          $error("index: expected %0d, actual %0d", want.index, out_index);
          failures++;
        end
        if (out_status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, out_status);
          failures++;
        end
        if (out_entry_count !== want.entry_count) begin
          $error("entry_count: expected %0d, actual %0d", want.entry_count, out_entry_count);
          failures++;
        end
      end
    end
  end

  // Hang detector: any beat on either channel restarts the count.
  initial begin : watchdog
    quiet_cycles = 0;
    while (quiet_cycles < HANG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  // Test sequence.
  initial begin
    failures    = 0;
    tx_gap_max  = 3;
    rx_gap_max  = 3;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_req_type = REQ_FIND;
    in_value    = '0;
    in_position = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_empty_table();
    test_boundary_values();
    test_full_table();
    test_mixed_traffic();

    @(negedge clk);
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failures == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
